@@ rtl/core/sttok_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Script tokenizer package
// Shared types, character codes, token kinds and keyword lookup.
// ----------------------------------------------------------------------------
package sttok_pkg;

  localparam int KIND_W = 5;
  localparam int OP_W   = 4;
  localparam int LINE_W = 16;
  localparam int NUM_W  = 29;
  localparam int OFF_W  = 20;
  localparam int TLEN_W = 13;
  localparam int STAT_W = 3;

  // Largest number literal value accepted.
  localparam logic [32:0] NUM_LIMIT = 33'd390451572;

  // Entries in the result queue; a byte can make up to three results.
  localparam int Q_DEPTH = 4;
  localparam int QI_W    = $clog2(Q_DEPTH);
  localparam int QC_W    = $clog2(Q_DEPTH + 1);

  localparam logic [KIND_W-1:0] K_NUMBER   = 5'd0;
  localparam logic [KIND_W-1:0] K_IDENT    = 5'd1;
  localparam logic [KIND_W-1:0] K_STRING   = 5'd2;
  localparam logic [KIND_W-1:0] K_GET      = 5'd3;
  localparam logic [KIND_W-1:0] K_SET      = 5'd4;
  localparam logic [KIND_W-1:0] K_INT      = 5'd5;
  localparam logic [KIND_W-1:0] K_STR_DECL = 5'd6;
  localparam logic [KIND_W-1:0] K_BOOL     = 5'd7;
  localparam logic [KIND_W-1:0] K_CALL     = 5'd8;
  localparam logic [KIND_W-1:0] K_TRUE     = 5'd9;
  localparam logic [KIND_W-1:0] K_FALSE    = 5'd10;
  localparam logic [KIND_W-1:0] K_IF       = 5'd11;
  localparam logic [KIND_W-1:0] K_LOOP     = 5'd12;
  localparam logic [KIND_W-1:0] K_NEXT     = 5'd13;
  localparam logic [KIND_W-1:0] K_END      = 5'd14;
  localparam logic [KIND_W-1:0] K_LPAREN   = 5'd15;
  localparam logic [KIND_W-1:0] K_RPAREN   = 5'd16;
  localparam logic [KIND_W-1:0] K_COLON    = 5'd17;
  localparam logic [KIND_W-1:0] K_DOT      = 5'd18;
  localparam logic [KIND_W-1:0] K_LBRACK   = 5'd19;
  localparam logic [KIND_W-1:0] K_RBRACK   = 5'd20;
  localparam logic [KIND_W-1:0] K_CONST    = 5'd21;
  localparam logic [KIND_W-1:0] K_OPER     = 5'd22;
  localparam logic [KIND_W-1:0] K_DONE     = 5'd23;
  localparam logic [KIND_W-1:0] K_ERROR    = 5'd24;

  localparam logic [OP_W-1:0] OP_ADD = 4'd0;
  localparam logic [OP_W-1:0] OP_SUB = 4'd1;
  localparam logic [OP_W-1:0] OP_MUL = 4'd2;
  localparam logic [OP_W-1:0] OP_DIV = 4'd3;
  localparam logic [OP_W-1:0] OP_LT  = 4'd4;
  localparam logic [OP_W-1:0] OP_NLT = 4'd5;
  localparam logic [OP_W-1:0] OP_GT  = 4'd6;
  localparam logic [OP_W-1:0] OP_NGT = 4'd7;
  localparam logic [OP_W-1:0] OP_EQ  = 4'd8;
  localparam logic [OP_W-1:0] OP_NE  = 4'd9;
  localparam logic [OP_W-1:0] OP_AND = 4'd10;
  localparam logic [OP_W-1:0] OP_OR  = 4'd11;
  localparam logic [OP_W-1:0] OP_XOR = 4'd12;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_TOK_FULL  = 3'd1;
  localparam logic [STAT_W-1:0] ST_INT_BIG   = 3'd2;
  localparam logic [STAT_W-1:0] ST_STORE     = 3'd3;
  localparam logic [STAT_W-1:0] ST_BANG_END  = 3'd4;
  localparam logic [STAT_W-1:0] ST_BANG_BAD  = 3'd5;
  localparam logic [STAT_W-1:0] ST_BAD_CHAR  = 3'd6;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_QUOT = 8'h22;
  localparam logic [7:0] CH_PCT  = 8'h25;
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_LPAR = 8'h28;
  localparam logic [7:0] CH_RPAR = 8'h29;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_EQ   = 8'h3D;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UZ   = 8'h5A;
  localparam logic [7:0] CH_LBRK = 8'h5B;
  localparam logic [7:0] CH_RBRK = 8'h5D;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LZ   = 8'h7A;
  localparam logic [7:0] CH_BAR  = 8'h7C;

  typedef enum logic [3:0] {
    M_IDLE, M_COMMENT, M_NUMBER, M_WORD, M_PRENAME, M_PRENAME_COMMENT,
    M_NAME, M_POSTCOLON, M_POSTCOLON_COMMENT, M_STRING, M_BANG
  } lex_mode_t;

  typedef struct packed {
    logic [KIND_W-1:0] token_kind;
    logic [OP_W-1:0]   operator_code;
    logic [LINE_W-1:0] line_number;
    logic [NUM_W-1:0]  number_value;
    logic [OFF_W-1:0]  text_offset;
    logic [TLEN_W-1:0] text_length;
    logic [STAT_W-1:0] status;
    logic              last_result;
  } res_t;

  // Results of one byte, oldest first in item[0].
  typedef struct packed {
    logic [1:0]      count;
    res_t [2:0]      item;
  } push_t;

  typedef struct packed {
    logic              hit;
    logic [KIND_W-1:0] kind;
    logic              colon;
  } kw_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_ident(input logic [7:0] c);
    return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ)) ||
           (c == CH_UNDER) || is_digit(c);
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_LF) || (c == CH_CR) || (c == CH_TAB) ||
           (c == CH_PCT);
  endfunction

  function automatic kw_t mk_kw(input logic [KIND_W-1:0] k, input logic col);
    kw_t r;
    r.hit   = 1'b1;
    r.kind  = k;
    r.colon = col;
    return r;
  endfunction

  // Keyword match on the first six characters and the exact length; a
  // length code of zero stands for a word longer than six characters.
  function automatic kw_t kw_lookup(input logic [47:0] p, input logic [2:0] n);
    kw_t r;
    r = '0;
    case (n)
      3'd2: if (p == 48'("if")) r = mk_kw(K_IF, 1'b0);
      3'd3: begin
        if (p == 48'("get")) r = mk_kw(K_GET, 1'b0);
        else if (p == 48'("set")) r = mk_kw(K_SET, 1'b0);
        else if (p == 48'("int")) r = mk_kw(K_INT, 1'b1);
        else if (p == 48'("end")) r = mk_kw(K_END, 1'b0);
      end
      3'd4: begin
        if (p == 48'("bool")) r = mk_kw(K_BOOL, 1'b1);
        else if (p == 48'("call")) r = mk_kw(K_CALL, 1'b0);
        else if (p == 48'("true")) r = mk_kw(K_TRUE, 1'b0);
        else if (p == 48'("loop")) r = mk_kw(K_LOOP, 1'b0);
        else if (p == 48'("next")) r = mk_kw(K_NEXT, 1'b0);
      end
      3'd5: begin
        if (p == 48'("false")) r = mk_kw(K_FALSE, 1'b0);
        else if (p == 48'("const")) r = mk_kw(K_CONST, 1'b0);
      end
      3'd6: if (p == 48'("string")) r = mk_kw(K_STR_DECL, 1'b1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/sttok_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Script tokenizer channels
// Byte input channel and token result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sttok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_text;

  modport source (output valid, output ch, output end_of_text, input ready);
  modport sink (input valid, input ch, input end_of_text, output ready);
endinterface

interface sttok_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [3:0]  operator_code;
  logic [15:0] line_number;
  logic [28:0] number_value;
  logic [19:0] text_offset;
  logic [12:0] text_length;
  logic [2:0]  status;
  logic        last_result;

  modport source (output valid, output token_kind, output operator_code,
                  output line_number, output number_value, output text_offset,
                  output text_length, output status, output last_result,
                  input ready);
  modport sink (input valid, input token_kind, input operator_code,
                input line_number, input number_value, input text_offset,
                input text_length, input status, input last_result,
                output ready);
endinterface

@@ rtl/core/sttok_lexer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Script tokenizer lexer
// Input byte register, lexer state and the single-pass step that turns one
// byte into up to three results.
// ----------------------------------------------------------------------------
module sttok_lexer #(
  parameter int MAX_TOKENS    = 4096,
  parameter int STORE_SIZE    = 4096,
  parameter int NAME_MAX      = 79,
  parameter int POSITION_BITS = 20,
  parameter int LINE_BITS     = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  sttok_in_if.sink          in_stream,
  input  logic              room_i,
  output sttok_pkg::push_t  push_o
);
  import sttok_pkg::*;

  localparam int LEN_MAX = (STORE_SIZE > NAME_MAX) ? STORE_SIZE : NAME_MAX;
  localparam int LEN_W   = $clog2(LEN_MAX + 2);
  localparam int SUM_W   = LEN_W + 1;
  localparam int CNT_W   = $clog2(MAX_TOKENS + 4) + 1;
  localparam int TS_W    = POSITION_BITS + 1;
  localparam int NSLOT   = 6;

  logic                     in_vld_r, in_vld_nxt;
  logic [7:0]               ch_r;
  logic                     eot_r;
  logic                     step_en;

  lex_mode_t                mode_r, mode_nxt;
  logic [NUM_W-1:0]         acc_r, acc_nxt;
  logic [47:0]              pre_r, pre_nxt;
  logic [LEN_W-1:0]         wl_r, wl_nxt;
  logic [KIND_W-1:0]        pk_r, pk_nxt;
  logic                     cs_r, cs_nxt;
  logic [POSITION_BITS-1:0] ts_r, ts_nxt;
  logic [POSITION_BITS-1:0] bp_r, bp_nxt;
  logic [LINE_BITS-1:0]     ln_r, ln_nxt;
  logic [LEN_W-1:0]         su_r, su_nxt;
  logic [CNT_W-1:0]         tc_r, tc_nxt;
  logic                     eh_r, eh_nxt;

  res_t                     slot [NSLOT];
  logic [NSLOT-1:0]         slot_v;

  assign in_stream.ready = !in_vld_r || room_i;
  assign step_en         = in_vld_r && room_i;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_stream.valid && in_stream.ready) begin
      in_vld_nxt = 1'b1;
    end else if (step_en) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
    if (in_stream.valid && in_stream.ready) begin
      ch_r  <= in_stream.ch;
      eot_r <= in_stream.end_of_text;
    end
  end

  function automatic res_t mk(input logic [KIND_W-1:0] k, input logic [OP_W-1:0] op,
                              input logic [NUM_W-1:0] v, input logic [OFF_W-1:0] off,
                              input logic [TLEN_W-1:0] len, input logic [STAT_W-1:0] st,
                              input logic last, input logic [LINE_W-1:0] ln);
    res_t r;
    r.token_kind    = k;
    r.operator_code = op;
    r.line_number   = ln;
    r.number_value  = v;
    r.text_offset   = off;
    r.text_length   = len;
    r.status        = st;
    r.last_result   = last;
    return r;
  endfunction

  // Next state: one byte through the mode handler, the keyword check of
  // an ended word, a possible re-dispatch of the same byte, then the
  // end-of-text wrap-up. Each stage fills its own result slots.
  always_comb begin
    lex_mode_t            mode;
    logic [NUM_W-1:0]     acc;
    logic [47:0]          pre;
    logic [LEN_W-1:0]     wl;
    logic [KIND_W-1:0]    pk;
    logic                 cs;
    logic [TS_W-1:0]      ts;
    logic [POSITION_BITS-1:0] bp;
    logic [LINE_BITS-1:0] ln;
    logic [LEN_W-1:0]     su;
    logic [CNT_W-1:0]     tc;
    logic                 eh;
    logic                 fl;
    logic                 p2;
    logic                 fw;
    logic [32:0]          v;
    logic [7:0]           c;
    kw_t                  kw;
    logic [2:0]           kl;
    logic [SUM_W-1:0]     sum;

    mode = mode_r; acc = acc_r; pre = pre_r; wl = wl_r; pk = pk_r; cs = cs_r;
    ts = TS_W'(ts_r); bp = bp_r; ln = ln_r; su = su_r; tc = tc_r; eh = eh_r;
    fl = 1'b0; p2 = 1'b0; fw = 1'b0; v = '0; c = ch_r; kw = '0; kl = '0; sum = '0;
    for (int k = 0; k < NSLOT; k++) begin
      slot[k] = '0;
    end
    slot_v = '0;

    if (step_en && eh_r) begin
      if (eot_r) begin
        mode = M_IDLE; acc = '0; pre = '0; wl = '0; pk = '0; cs = 1'b0; ts = '0;
        bp = '0; ln = '0; su = '0; tc = '0; eh = 1'b0;
      end
    end else if (step_en) begin
      // First pass on the current mode.
      unique case (mode)
        M_COMMENT, M_PRENAME_COMMENT, M_POSTCOLON_COMMENT: begin
          if (c == CH_LF) begin
            if (ln != '1) ln = ln + 1'b1;
            mode = (mode == M_COMMENT) ? M_IDLE :
                   (mode == M_PRENAME_COMMENT) ? M_PRENAME : M_POSTCOLON;
          end
        end
        M_NUMBER: begin
          if (is_digit(c)) begin
            v = 33'(acc) * 33'd10 + 33'(c - CH_0);
            if (v > NUM_LIMIT) begin
              slot[0] = mk(K_ERROR, OP_ADD, '0, '0, '0, ST_INT_BIG, 1'b1, LINE_W'(ln));
              slot_v[0] = 1'b1; fl = 1'b1; eh = 1'b1;
            end else begin
              acc = v[NUM_W-1:0];
            end
          end else begin
            slot[0] = mk(K_NUMBER, OP_ADD, acc, '0, '0, ST_OK, 1'b0, LINE_W'(ln));
            slot_v[0] = 1'b1; tc = tc + 1'b1;
            mode = M_IDLE; p2 = 1'b1;
          end
        end
        M_WORD: begin
          if (is_ident(c)) begin
            if (wl < LEN_W'(6)) pre = {pre[39:0], c};
            wl = wl + 1'b1;
            if (wl >= LEN_W'(NAME_MAX)) fw = 1'b1;
          end else begin
            fw = 1'b1; p2 = 1'b1;
          end
        end
        M_NAME: begin
          if (is_ident(c)) begin
            wl = wl + 1'b1;
            sum = SUM_W'(su) + SUM_W'(wl);
            if (sum >= SUM_W'(STORE_SIZE)) begin
              slot[0] = mk(K_ERROR, OP_ADD, '0, '0, '0, ST_STORE, 1'b1, LINE_W'(ln));
              slot_v[0] = 1'b1; fl = 1'b1; eh = 1'b1;
            end
          end else begin
            slot[0] = mk(pk, OP_ADD, '0, OFF_W'(ts), TLEN_W'(wl), ST_OK, 1'b0,
                         LINE_W'(ln));
            slot_v[0] = 1'b1; tc = tc + 1'b1;
            su = su + wl;
            if (cs && c == CH_COLON) begin
              mode = M_POSTCOLON;
            end else begin
              mode = M_IDLE; p2 = 1'b1;
            end
          end
        end
        M_POSTCOLON: begin
          if (is_ws(c)) begin
            if (c == CH_LF) begin
              if (ln != '1) ln = ln + 1'b1;
            end else if (c == CH_PCT) begin
              mode = M_POSTCOLON_COMMENT;
            end
          end else begin
            mode = M_IDLE; p2 = 1'b1;
          end
        end
        M_STRING: begin
          sum = SUM_W'(su) + SUM_W'(wl);
          if (c == CH_QUOT) begin
            slot[0] = mk(K_STRING, OP_ADD, '0, OFF_W'(ts), TLEN_W'(wl), ST_OK, 1'b0,
                         LINE_W'(ln));
            slot_v[0] = 1'b1; tc = tc + 1'b1;
            su = su + wl; mode = M_IDLE;
          end else if (sum >= SUM_W'(STORE_SIZE)) begin
            // Store is full: the string ends here and this byte starts anew.
            slot[0] = mk(K_STRING, OP_ADD, '0, OFF_W'(ts), TLEN_W'(wl), ST_OK, 1'b0,
                         LINE_W'(ln));
            slot_v[0] = 1'b1; tc = tc + 1'b1;
            su = su + wl; mode = M_IDLE; p2 = 1'b1;
          end else begin
            wl = wl + 1'b1;
            if (c == CH_LF && ln != '1) ln = ln + 1'b1;
          end
        end
        M_BANG: begin
          mode = M_IDLE;
          if (c == CH_LT || c == CH_GT || c == CH_EQ) begin
            slot[0] = mk(K_OPER, (c == CH_LT) ? OP_NLT : (c == CH_GT) ? OP_NGT : OP_NE,
                         '0, '0, '0, ST_OK, 1'b0, LINE_W'(ln));
            slot_v[0] = 1'b1; tc = tc + 1'b1;
          end else begin
            slot[0] = mk(K_ERROR, OP_ADD, '0, '0, '0, ST_BANG_BAD, 1'b1, LINE_W'(ln));
            slot_v[0] = 1'b1; fl = 1'b1; eh = 1'b1;
          end
        end
        default: begin
          p2 = 1'b1;
        end
      endcase

      // Word ended: keyword or identifier.
      if (fw) begin
        kl = (wl <= LEN_W'(6)) ? wl[2:0] : 3'd0;
        kw = kw_lookup(pre, kl);
        if (kw.hit) begin
          if (kw.kind <= K_CALL) begin
            pk = kw.kind; cs = kw.colon; mode = M_PRENAME;
          end else begin
            slot[1] = mk(kw.kind, OP_ADD, '0, '0, '0, ST_OK, 1'b0, LINE_W'(ln));
            slot_v[1] = 1'b1; tc = tc + 1'b1; mode = M_IDLE;
          end
        end else begin
          mode = M_IDLE;
          sum = SUM_W'(su) + SUM_W'(wl);
          if (sum > SUM_W'(STORE_SIZE)) begin
            slot[1] = mk(K_ERROR, OP_ADD, '0, '0, '0, ST_STORE, 1'b1, LINE_W'(ln));
            slot_v[1] = 1'b1; fl = 1'b1; eh = 1'b1;
          end else begin
            slot[1] = mk(K_IDENT, OP_ADD, '0, OFF_W'(ts), TLEN_W'(wl), ST_OK, 1'b0,
                         LINE_W'(ln));
            slot_v[1] = 1'b1; tc = tc + 1'b1; su = su + wl;
          end
        end
      end

      // The byte handled in idle or before a keyword's name.
      if (p2 && !fl) begin
        if (mode == M_PRENAME) begin
          if (is_ws(c)) begin
            if (c == CH_LF) begin
              if (ln != '1) ln = ln + 1'b1;
            end else if (c == CH_PCT) begin
              mode = M_PRENAME_COMMENT;
            end
          end else begin
            ts = TS_W'(bp); wl = LEN_W'(1); mode = M_NAME;
            sum = SUM_W'(su) + SUM_W'(1);
            if (sum >= SUM_W'(STORE_SIZE)) begin
              slot[2] = mk(K_ERROR, OP_ADD, '0, '0, '0, ST_STORE, 1'b1, LINE_W'(ln));
              slot_v[2] = 1'b1; fl = 1'b1; eh = 1'b1;
            end
          end
        end else begin
          mode = M_IDLE;
          if (tc >= CNT_W'(MAX_TOKENS)) begin
            slot[2] = mk(K_ERROR, OP_ADD, '0, '0, '0, ST_TOK_FULL, 1'b1, LINE_W'(ln));
            slot_v[2] = 1'b1; fl = 1'b1; eh = 1'b1;
          end else begin
            case (c) inside
              CH_SP, CH_CR, CH_TAB: begin
              end
              CH_LF: begin
                if (ln != '1) ln = ln + 1'b1;
              end
              CH_PCT: mode = M_COMMENT;
              CH_QUOT: begin
                ts = TS_W'(bp) + 1'b1; wl = '0; mode = M_STRING;
              end
              CH_LPAR, CH_RPAR, CH_COLON, CH_DOT, CH_LBRK, CH_RBRK: begin
                slot[2] = mk((c == CH_LPAR) ? K_LPAREN : (c == CH_RPAR) ? K_RPAREN :
                             (c == CH_COLON) ? K_COLON : (c == CH_DOT) ? K_DOT :
                             (c == CH_LBRK) ? K_LBRACK : K_RBRACK,
                             OP_ADD, '0, '0, '0, ST_OK, 1'b0, LINE_W'(ln));
                slot_v[2] = 1'b1; tc = tc + 1'b1;
              end
              CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LT, CH_GT, CH_EQ, CH_AMP,
              CH_BAR, CH_CARET: begin
                slot[2] = mk(K_OPER,
                             (c == CH_PLUS) ? OP_ADD : (c == CH_MINUS) ? OP_SUB :
                             (c == CH_STAR) ? OP_MUL : (c == CH_SLASH) ? OP_DIV :
                             (c == CH_LT) ? OP_LT : (c == CH_GT) ? OP_GT :
                             (c == CH_EQ) ? OP_EQ : (c == CH_AMP) ? OP_AND :
                             (c == CH_BAR) ? OP_OR : OP_XOR,
                             '0, '0, '0, ST_OK, 1'b0, LINE_W'(ln));
                slot_v[2] = 1'b1; tc = tc + 1'b1;
              end
              CH_BANG: mode = M_BANG;
              default: begin
                if (is_digit(c)) begin
                  acc = NUM_W'(c - CH_0); mode = M_NUMBER;
                end else if (is_ident(c)) begin
                  pre = 48'(c); wl = LEN_W'(1); ts = TS_W'(bp); mode = M_WORD;
                end else begin
                  slot[2] = mk(K_ERROR, OP_ADD, '0, '0, '0, ST_BAD_CHAR, 1'b1,
                               LINE_W'(ln));
                  slot_v[2] = 1'b1; fl = 1'b1; eh = 1'b1;
                end
              end
            endcase
          end
        end
      end

      // End of text: close the open lexeme, then report done if no error was raised.
      if (eot_r && !fl) begin
        case (mode)
          M_NUMBER: begin
            slot[4] = mk(K_NUMBER, OP_ADD, acc, '0, '0, ST_OK, 1'b0, LINE_W'(ln));
            slot_v[4] = 1'b1;
          end
          M_WORD: begin
            kl = (wl <= LEN_W'(6)) ? wl[2:0] : 3'd0;
            kw = kw_lookup(pre, kl);
            if (kw.hit) begin
              if (kw.kind <= K_CALL) begin
                // Keyword with no name before the end.
                slot[4] = mk(kw.kind, OP_ADD, '0, '0, '0, ST_OK, 1'b0, LINE_W'(ln));
              end else begin
                slot[4] = mk(kw.kind, OP_ADD, '0, '0, '0, ST_OK, 1'b0, LINE_W'(ln));
              end
              slot_v[4] = 1'b1;
            end else begin
              sum = SUM_W'(su) + SUM_W'(wl);
              if (sum > SUM_W'(STORE_SIZE)) begin
                slot[3] = mk(K_ERROR, OP_ADD, '0, '0, '0, ST_STORE, 1'b1, LINE_W'(ln));
                slot_v[3] = 1'b1; fl = 1'b1;
              end else begin
                slot[3] = mk(K_IDENT, OP_ADD, '0, OFF_W'(ts), TLEN_W'(wl), ST_OK, 1'b0,
                             LINE_W'(ln));
                slot_v[3] = 1'b1;
              end
            end
          end
          M_PRENAME, M_PRENAME_COMMENT: begin
            slot[4] = mk(pk, OP_ADD, '0, '0, '0, ST_OK, 1'b0, LINE_W'(ln));
            slot_v[4] = 1'b1;
          end
          M_NAME: begin
            slot[4] = mk(pk, OP_ADD, '0, OFF_W'(ts), TLEN_W'(wl), ST_OK, 1'b0,
                         LINE_W'(ln));
            slot_v[4] = 1'b1;
          end
          M_STRING: begin
            slot[4] = mk(K_STRING, OP_ADD, '0, OFF_W'(ts), TLEN_W'(wl), ST_OK, 1'b0,
                         LINE_W'(ln));
            slot_v[4] = 1'b1;
          end
          M_BANG: begin
            slot[5] = mk(K_ERROR, OP_ADD, '0, '0, '0, ST_BANG_END, 1'b1, LINE_W'(ln));
            slot_v[5] = 1'b1; fl = 1'b1;
          end
          default: begin
          end
        endcase
        if (!fl) begin
          slot[5] = mk(K_DONE, OP_ADD, '0, '0, '0, ST_OK, 1'b1, LINE_W'(ln));
          slot_v[5] = 1'b1;
        end
      end

      bp = bp + 1'b1;
      ts[TS_W-1] = 1'b0;
      if (eot_r) begin
        mode = M_IDLE; acc = '0; pre = '0; wl = '0; pk = '0; cs = 1'b0; ts = '0;
        bp = '0; ln = '0; su = '0; tc = '0; eh = 1'b0;
      end
    end

    mode_nxt = mode; acc_nxt = acc; pre_nxt = pre; wl_nxt = wl; pk_nxt = pk;
    cs_nxt = cs; ts_nxt = ts[POSITION_BITS-1:0]; bp_nxt = bp; ln_nxt = ln;
    su_nxt = su; tc_nxt = tc; eh_nxt = eh;
  end

  // Outputs: packs the filled slots in order into the push bundle.
  always_comb begin
    logic [2:0] n;
    n = '0;
    push_o = '0;
    for (int k = 0; k < NSLOT; k++) begin
      if (slot_v[k] && n != 3'd3) begin
        push_o.item[n[1:0]] = slot[k];
        n = n + 1'b1;
      end
    end
    push_o.count = n[1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      acc_r  <= '0;
      pre_r  <= '0;
      wl_r   <= '0;
      pk_r   <= '0;
      cs_r   <= 1'b0;
      ts_r   <= '0;
      bp_r   <= '0;
      ln_r   <= '0;
      su_r   <= '0;
      tc_r   <= '0;
      eh_r   <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      pre_r  <= pre_nxt;
      wl_r   <= wl_nxt;
      pk_r   <= pk_nxt;
      cs_r   <= cs_nxt;
      ts_r   <= ts_nxt;
      bp_r   <= bp_nxt;
      ln_r   <= ln_nxt;
      su_r   <= su_nxt;
      tc_r   <= tc_nxt;
      eh_r   <= eh_nxt;
    end
  end

endmodule

@@ rtl/core/sttok_result_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Script tokenizer result queue
// Four-entry queue that takes up to three results a cycle and hands one a
// cycle to the result channel while the channel is ready.
// ----------------------------------------------------------------------------
module sttok_result_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  sttok_pkg::push_t push_i,
  output logic             room_o,
  sttok_out_if.source      out_stream
);
  import sttok_pkg::*;

  res_t            mem [Q_DEPTH];
  logic [QI_W-1:0] wp_r, wp_nxt;
  logic [QI_W-1:0] rp_r, rp_nxt;
  logic [QC_W-1:0] count_r, count_nxt;
  logic            pop;
  res_t            head;

  assign room_o = (count_r <= QC_W'(Q_DEPTH - 3));
  assign pop    = out_stream.valid && out_stream.ready;
  assign head   = mem[rp_r];

  assign out_stream.valid         = (count_r != '0);
  assign out_stream.token_kind    = head.token_kind;
  assign out_stream.operator_code = head.operator_code;
  assign out_stream.line_number   = head.line_number;
  assign out_stream.number_value  = head.number_value;
  assign out_stream.text_offset   = head.text_offset;
  assign out_stream.text_length   = head.text_length;
  assign out_stream.status        = head.status;
  assign out_stream.last_result   = head.last_result;

  always_comb begin
    wp_nxt    = wp_r + QI_W'(push_i.count);
    rp_nxt    = rp_r + QI_W'(pop);
    count_nxt = count_r + QC_W'(push_i.count) - QC_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      count_r <= count_nxt;
    end
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push_i.count) begin
        mem[wp_r + QI_W'(i)] <= push_i.item[i];
      end
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QC_W'(Q_DEPTH))
    else $error("result queue holds more entries than it has");

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push_i.count != 2'd0) |-> room_o)
    else $error("results pushed without room for a full byte");

  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (count_r == $past(count_r) + QC_W'($past(push_i.count))
                      - QC_W'($past(pop))))
    else $error("queue fill level lost a request");

endmodule

@@ rtl/core/script_text_tokenizer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Script text tokenizer
// Turns a stream of script text bytes into tokens with offsets and lengths.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle while the queue has room and
// makes zero to three tokens for it; a byte is registered on entry, and
// its results go into a four-entry queue that feeds the result channel
// one request per cycle while the channel is ready. Input ready stays high
// as long as the queue has room for three results, so text that makes at
// most one token per byte flows at one byte per cycle; a byte that closes
// one lexeme and opens another, or ends the text, stalls the input. Token
// text is reported as the input offset and length only.
module script_text_tokenizer_unit #(
  parameter int MAX_TOKENS    = 4096,
  parameter int STORE_SIZE    = 4096,
  parameter int NAME_MAX      = 79,
  parameter int POSITION_BITS = 20,
  parameter int LINE_BITS     = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  sttok_in_if.sink    in_stream,
  sttok_out_if.source out_stream
);
  import sttok_pkg::*;

  push_t push;
  logic  room;

  sttok_lexer #(
    .MAX_TOKENS    (MAX_TOKENS),
    .STORE_SIZE    (STORE_SIZE),
    .NAME_MAX      (NAME_MAX),
    .POSITION_BITS (POSITION_BITS),
    .LINE_BITS     (LINE_BITS)
  ) u_lexer (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stream (in_stream),
    .room_i    (room),
    .push_o    (push)
  );

  sttok_result_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (push),
    .room_o     (room),
    .out_stream (out_stream)
  );

endmodule
